// ===== sv/slbm_pkg.sv =====
// ----------------------------------------------------------------------------
// slbm_pkg: shared types and constants for the serial load bank mapper
// Field widths, register codes and the structs passed between modules.
// ----------------------------------------------------------------------------
package slbm_pkg;

   localparam int ADDR_W       = 15;
   localparam int DATA_W       = 8;
   localparam int ROM_ADDR_W   = 18;
   localparam int OFFSET_W     = 14;
   localparam int BANK_W       = 4;
   localparam int COUNT_W      = 5;
   localparam int SERIAL_W     = 5;
   localparam int SCOUNT_W     = 3;
   localparam int MIRROR_W     = 2;
   localparam int CHR_W        = 5;

   localparam logic [COUNT_W-1:0]  MAX_PRG_BANKS   = 5'd16;
   localparam logic [COUNT_W-1:0]  PRG_COUNT_RESET = 5'd2;
   localparam logic [SCOUNT_W-1:0] SERIAL_LAST     = 3'd4;

   localparam int CLEAR_BIT  = 7;
   localparam int HALF_BIT   = 14;
   localparam int TARGET_LSB = 13;

   // load target, from address bits 14:13
   typedef enum logic [1:0] {
      TGT_MIRROR = 2'd0,
      TGT_CHR    = 2'd1,
      TGT_IGNORE = 2'd2,
      TGT_PRG    = 2'd3
   } target_type;

   typedef struct packed {
      logic       valid;
      logic       clear;
      logic       serial_bit;
      target_type target;
   } write_cmd_type;

   typedef struct packed {
      logic [MIRROR_W-1:0] mirror;
      logic [CHR_W-1:0]    char_page;
      logic [BANK_W-1:0]   prog_page;
   } bank_state_type;

endpackage

// ===== sv/slbm_serial_regs.sv =====
// ----------------------------------------------------------------------------
// slbm_serial_regs: serial load port and mapper registers
// Shifts in one bit per write without the clear bit, and on the fifth loads the selected register.
// ----------------------------------------------------------------------------
module slbm_serial_regs (
   input  logic                     clock,
   input  logic                     reset,
   input  slbm_pkg::write_cmd_type  cmd,
   output slbm_pkg::bank_state_type state,
   output slbm_pkg::bank_state_type state_next
);

   logic [slbm_pkg::SERIAL_W-1:0] serial_bits_ff, serial_bits_in;
   logic [slbm_pkg::SCOUNT_W-1:0] serial_count_ff, serial_count_in;
   slbm_pkg::bank_state_type      regs_ff, regs_in;
   logic [slbm_pkg::SERIAL_W-1:0] value;

   always_comb begin
      serial_bits_in  = serial_bits_ff;
      serial_count_in = serial_count_ff;
      regs_in         = regs_ff;
      // fifth bit lands in bit 4
      value           = {cmd.serial_bit, serial_bits_ff[slbm_pkg::SERIAL_W-2:0]};
      if (cmd.valid) begin
         if (cmd.clear) begin
            serial_bits_in  = '0;
            serial_count_in = '0;
         end else if (serial_count_ff != slbm_pkg::SERIAL_LAST) begin
            serial_bits_in  = serial_bits_ff
                              | (slbm_pkg::SERIAL_W'(cmd.serial_bit) << serial_count_ff);
            serial_count_in = serial_count_ff + slbm_pkg::SCOUNT_W'(1);
         end else begin
            unique case (cmd.target)
               slbm_pkg::TGT_MIRROR: regs_in.mirror    = value[slbm_pkg::MIRROR_W-1:0];
               slbm_pkg::TGT_CHR:    regs_in.char_page = value[slbm_pkg::CHR_W-1:0];
               slbm_pkg::TGT_IGNORE: regs_in          = regs_ff;
               slbm_pkg::TGT_PRG:    regs_in.prog_page = value[slbm_pkg::BANK_W-1:0];
               default:              regs_in          = regs_ff;
            endcase
            serial_bits_in  = '0;
            serial_count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         serial_bits_ff  <= '0;
         serial_count_ff <= '0;
         regs_ff         <= '0;
      end else begin
         serial_bits_ff  <= serial_bits_in;
         serial_count_ff <= serial_count_in;
         regs_ff         <= regs_in;
      end
   end

   assign state      = regs_ff;
   assign state_next = regs_in;

endmodule

// ===== sv/slbm_rom_map.sv =====
// ----------------------------------------------------------------------------
// slbm_rom_map: program read address translation
// Low half maps through the switchable bank, high half through the last bank.
// ----------------------------------------------------------------------------
module slbm_rom_map (
   input  logic [slbm_pkg::ADDR_W-1:0]     address,
   input  logic [slbm_pkg::BANK_W-1:0]     prog_page,
   input  logic [slbm_pkg::COUNT_W-1:0]    bank_count,
   output logic [slbm_pkg::ROM_ADDR_W-1:0] rom_address,
   output logic                            out_of_range
);

   logic [slbm_pkg::COUNT_W-1:0] count_eff;
   logic [slbm_pkg::COUNT_W-1:0] last_bank;
   logic [slbm_pkg::BANK_W-1:0]  bank;

   always_comb begin
      count_eff = (bank_count > slbm_pkg::MAX_PRG_BANKS) ? slbm_pkg::MAX_PRG_BANKS
                                                         : bank_count;
      // empty bank count: last bank taken as 0, always flagged
      last_bank = (count_eff == '0) ? '0 : count_eff - slbm_pkg::COUNT_W'(1);
      if (address[slbm_pkg::HALF_BIT]) begin
         bank = last_bank[slbm_pkg::BANK_W-1:0];
      end else begin
         bank = prog_page;
      end
      out_of_range = (slbm_pkg::COUNT_W'(bank) >= count_eff);
      rom_address  = {bank, address[slbm_pkg::OFFSET_W-1:0]};
   end

endmodule

// ===== sv/serial_load_bank_mapper.sv =====
// Each accepted request word passes the input register, then the result register.
// Throughput: one word per cycle while the response side does not stall.
// A response stall with the input stage full stalls the request side in the same cycle.
// Reset (synchronous, active high) empties both stages, clears the serial
// port and mapper registers, and sets the bank count to 2.
// ----------------------------------------------------------------------------
// serial_load_bank_mapper: serially loaded program bank mapper
// Writes load a 5-bit serial port into mapper registers; reads are mapped
// to program ROM byte addresses with an out-of-range flag.
// ----------------------------------------------------------------------------
module serial_load_bank_mapper (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [slbm_pkg::ADDR_W-1:0]     req_address,
   input  logic [slbm_pkg::DATA_W-1:0]     req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [slbm_pkg::ROM_ADDR_W-1:0] rsp_rom_address,
   output logic                            rsp_bank_out_of_range,
   output logic [slbm_pkg::MIRROR_W-1:0]   rsp_mirroring_mode,
   output logic [slbm_pkg::CHR_W-1:0]      rsp_chr_bank_select,
   output logic [slbm_pkg::BANK_W-1:0]     rsp_prg_bank_select,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [slbm_pkg::COUNT_W-1:0]    csr_prg_bank_count
);

   logic                             s1_valid_ff;
   logic                             s1_command_ff;
   logic [slbm_pkg::ADDR_W-1:0]      s1_address_ff;
   logic [slbm_pkg::DATA_W-1:0]      s1_data_ff;
   logic [slbm_pkg::COUNT_W-1:0]     bank_count_ff;

   logic                             rsp_valid_ff;
   logic [slbm_pkg::ROM_ADDR_W-1:0]  rsp_rom_ff, rsp_rom_in;
   logic                             rsp_flag_ff, rsp_flag_in;
   slbm_pkg::bank_state_type         rsp_state_ff;

   logic                             out_free;
   logic                             s1_move;
   logic                             req_take;
   slbm_pkg::write_cmd_type          wr_cmd;
   slbm_pkg::bank_state_type         state, state_next;
   logic [slbm_pkg::ROM_ADDR_W-1:0]  map_rom;
   logic                             map_flag;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      wr_cmd.valid      = s1_move && s1_command_ff;
      wr_cmd.clear      = s1_data_ff[slbm_pkg::CLEAR_BIT];
      wr_cmd.serial_bit = s1_data_ff[0];
      wr_cmd.target     = slbm_pkg::target_type'(
                             s1_address_ff[slbm_pkg::TARGET_LSB +: 2]);
   end

   slbm_serial_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .cmd        (wr_cmd),
      .state      (state),
      .state_next (state_next)
   );

   slbm_rom_map u_map (
      .address      (s1_address_ff),
      .prog_page    (state.prog_page),
      .bank_count   (bank_count_ff),
      .rom_address  (map_rom),
      .out_of_range (map_flag)
   );

   // writes report zero address and no flag
   assign rsp_rom_in  = s1_command_ff ? '0 : map_rom;
   assign rsp_flag_in = s1_command_ff ? 1'b0 : map_flag;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         bank_count_ff <= slbm_pkg::PRG_COUNT_RESET;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (csr_valid && csr_ready) begin
            bank_count_ff <= csr_prg_bank_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_command_ff <= req_command;
         s1_address_ff <= req_address;
         s1_data_ff    <= req_data;
      end
      if (s1_move) begin
         rsp_rom_ff   <= rsp_rom_in;
         rsp_flag_ff  <= rsp_flag_in;
         rsp_state_ff <= state_next;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_rom_address       = rsp_rom_ff;
   assign rsp_bank_out_of_range = rsp_flag_ff;
   assign rsp_mirroring_mode    = rsp_state_ff.mirror;
   assign rsp_chr_bank_select   = rsp_state_ff.char_page;
   assign rsp_prg_bank_select   = rsp_state_ff.prog_page;

endmodule

// ===== tb/serial_load_bank_mapper_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_load_bank_mapper_tb: self-checking bench for the bank mapper
// Drives program reads and serial-load writes. A behavioral copy of the
// mapper predicts each response word, and every response is checked in order.
// Stalls on both sides, bank-count changes and back-to-back traffic at the end.
// ----------------------------------------------------------------------------
module serial_load_bank_mapper_tb;

   typedef struct packed {
      logic [slbm_pkg::ROM_ADDR_W-1:0] rom_address;
      logic                            out_of_range;
      logic [slbm_pkg::MIRROR_W-1:0]   mirror;
      logic [slbm_pkg::CHR_W-1:0]      char_page;
      logic [slbm_pkg::BANK_W-1:0]     prog_page;
   } map_result_type;

   logic                            clock              = 1'b0;
   logic                            reset              = 1'b1;
   logic                            req_valid          = 1'b0;
   logic                            req_stall;
   logic                            req_command        = 1'b0;
   logic [slbm_pkg::ADDR_W-1:0]     req_address        = '0;
   logic [slbm_pkg::DATA_W-1:0]     req_data           = '0;
   logic                            rsp_valid;
   logic                            rsp_stall          = 1'b0;
   logic [slbm_pkg::ROM_ADDR_W-1:0] rsp_rom_address;
   logic                            rsp_bank_out_of_range;
   logic [slbm_pkg::MIRROR_W-1:0]   rsp_mirroring_mode;
   logic [slbm_pkg::CHR_W-1:0]      rsp_chr_bank_select;
   logic [slbm_pkg::BANK_W-1:0]     rsp_prg_bank_select;
   logic                            csr_valid          = 1'b0;
   logic                            csr_ready;
   logic [slbm_pkg::COUNT_W-1:0]    csr_prg_bank_count = '0;

   // mapper state as the bench sees it
   logic [slbm_pkg::SERIAL_W-1:0]   shift_bits  = '0;
   logic [slbm_pkg::SCOUNT_W-1:0]   shift_count = '0;
   slbm_pkg::bank_state_type        mapper_regs = '0;
   logic [slbm_pkg::COUNT_W-1:0]    bank_count  = slbm_pkg::PRG_COUNT_RESET;

   map_result_type                  pending_maps[$];
   map_result_type                  rsp_got;
   map_result_type                  rsp_want;

   bit                              idle_on     = 1'b1;
   int                              stall_left  = 0;
   int                              mismatches  = 0;
   int                              words_sent  = 0;
   int                              rsp_checked = 0;
   int                              count_writes = 0;

   logic [slbm_pkg::COUNT_W-1:0]    phase_counts[7] =
      '{5'd2, 5'd1, 5'd16, 5'd0, 5'd9, 5'd31, 5'd17};

   serial_load_bank_mapper u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_command           (req_command),
      .req_address           (req_address),
      .req_data              (req_data),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_rom_address       (rsp_rom_address),
      .rsp_bank_out_of_range (rsp_bank_out_of_range),
      .rsp_mirroring_mode    (rsp_mirroring_mode),
      .rsp_chr_bank_select   (rsp_chr_bank_select),
      .rsp_prg_bank_select   (rsp_prg_bank_select),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_prg_bank_count    (csr_prg_bank_count)
   );

   always #2 clock = ~clock;

   // Advance the mapper copy by one accepted word and queue its response.
   task automatic map_access(input logic cmd, input logic [slbm_pkg::ADDR_W-1:0] addr,
                             input logic [slbm_pkg::DATA_W-1:0] data);
      logic [slbm_pkg::SERIAL_W-1:0] value;
      logic [slbm_pkg::COUNT_W-1:0]  count;
      logic [slbm_pkg::COUNT_W-1:0]  bank;
      map_result_type                r;
      r = '0;
      if (cmd) begin
         if (data[slbm_pkg::CLEAR_BIT]) begin
            shift_bits  = '0;
            shift_count = '0;
         end else if (shift_count < slbm_pkg::SERIAL_LAST) begin
            shift_bits[shift_count] = data[0];
            shift_count = shift_count + 1'b1;
         end else begin
            value = shift_bits;
            value[slbm_pkg::SERIAL_W-1] = data[0];
            case (slbm_pkg::target_type'(addr[slbm_pkg::HALF_BIT:slbm_pkg::TARGET_LSB]))
               slbm_pkg::TGT_MIRROR: mapper_regs.mirror = value[slbm_pkg::MIRROR_W-1:0];
               slbm_pkg::TGT_CHR:    mapper_regs.char_page = value;
               slbm_pkg::TGT_PRG:    mapper_regs.prog_page = value[slbm_pkg::BANK_W-1:0];
               default:              ;
            endcase
            shift_bits  = '0;
            shift_count = '0;
         end
      end else begin
         count = (bank_count > slbm_pkg::MAX_PRG_BANKS) ? slbm_pkg::MAX_PRG_BANKS
                                                        : bank_count;
         if (addr[slbm_pkg::HALF_BIT]) begin
            // fixed high bank; with no banks at all it falls back to bank 0
            bank = (count == '0) ? '0 : count - 1'b1;
         end else begin
            bank = {1'b0, mapper_regs.prog_page};
         end
         r.out_of_range = (bank >= count);
         r.rom_address  = {bank[slbm_pkg::BANK_W-1:0], addr[slbm_pkg::OFFSET_W-1:0]};
      end
      r.mirror    = mapper_regs.mirror;
      r.char_page = mapper_regs.char_page;
      r.prog_page = mapper_regs.prog_page;
      pending_maps.push_back(r);
   endtask

   // Valid is left high on return; the caller follows with another word or
   // with drain_words in the same step.
   task automatic send_word(input logic cmd, input logic [slbm_pkg::ADDR_W-1:0] addr,
                            input logic [slbm_pkg::DATA_W-1:0] data);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_address <= addr;
      req_data    <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      map_access(cmd, addr, data);
      words_sent++;
   endtask

   task automatic drain_words();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_maps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_bank_count(input logic [slbm_pkg::COUNT_W-1:0] value);
      drain_words();
      csr_valid          <= 1'b1;
      csr_prg_bank_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      bank_count = value;
      count_writes++;
      csr_valid <= 1'b0;
   endtask

   // Five serial writes, LSB first, with random filler in the unused bits.
   task automatic load_serial(input slbm_pkg::target_type tgt,
                              input logic [slbm_pkg::SERIAL_W-1:0] value);
      logic [12:0] low_addr;
      logic [5:0]  filler;
      for (int i = 0; i < slbm_pkg::SERIAL_W; i++) begin
         low_addr = 13'($urandom);
         filler   = 6'($urandom);
         send_word(1'b1, {tgt, low_addr}, {1'b0, filler, value[i]});
      end
   endtask

   task automatic test_reset_reads();
      send_word(1'b0, 15'h0000, 8'h00);
      send_word(1'b0, 15'h7FFF, 8'hFF);
   endtask

   task automatic test_serial_targets();
      // only the CHR register shows the fifth bit
      load_serial(slbm_pkg::TGT_CHR, 5'h10);
      load_serial(slbm_pkg::TGT_IGNORE, 5'h1F);
      // clear in the middle of a load
      send_word(1'b1, {slbm_pkg::TGT_PRG, 13'h0000}, 8'h01);
      send_word(1'b1, {slbm_pkg::TGT_PRG, 13'h1FFF}, 8'h00);
      send_word(1'b1, 15'h7FFF, 8'hFF);
      load_serial(slbm_pkg::TGT_PRG, 5'h0F);
   endtask

   task automatic test_bank_counts();
      logic [slbm_pkg::COUNT_W-1:0] counts[5] = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};
      foreach (counts[i]) begin
         set_bank_count(counts[i]);
         send_word(1'b0, 15'h0000, 8'h00);
         send_word(1'b0, 15'h7FFF, 8'h00);
      end
   endtask

   task automatic test_random(input int n_words);
      int                          sent;
      int                          kind;
      int                          burst;
      logic [slbm_pkg::ADDR_W-1:0] a;
      logic [slbm_pkg::DATA_W-1:0] d;
      sent = 0;
      while (sent < n_words) begin
         kind = $urandom_range(0, 19);
         if (kind < 10) begin
            if ($urandom_range(0, 1) == 1) begin
               a = slbm_pkg::ADDR_W'($urandom);
               d = slbm_pkg::DATA_W'($urandom);
               d[slbm_pkg::CLEAR_BIT] = 1'b1;
               send_word(1'b1, a, d);
               sent++;
            end
            load_serial(slbm_pkg::target_type'(2'($urandom_range(0, 3))),
                        slbm_pkg::SERIAL_W'($urandom_range(0, 31)));
            sent += slbm_pkg::SERIAL_W;
         end else if (kind < 12) begin
            // partial load, then a clear
            burst = $urandom_range(1, 4);
            repeat (burst) begin
               a = slbm_pkg::ADDR_W'($urandom);
               d = slbm_pkg::DATA_W'($urandom);
               d[slbm_pkg::CLEAR_BIT] = 1'b0;
               send_word(1'b1, a, d);
            end
            a = slbm_pkg::ADDR_W'($urandom);
            d = slbm_pkg::DATA_W'($urandom);
            d[slbm_pkg::CLEAR_BIT] = 1'b1;
            send_word(1'b1, a, d);
            sent += burst + 1;
         end else if (kind < 18) begin
            burst = $urandom_range(1, 4);
            repeat (burst) begin
               a = slbm_pkg::ADDR_W'($urandom);
               d = slbm_pkg::DATA_W'($urandom);
               send_word(1'b0, a, d);
            end
            sent += burst;
         end else begin
            a = slbm_pkg::ADDR_W'($urandom);
            d = slbm_pkg::DATA_W'($urandom);
            send_word((kind == 18) ? 1'b1 : 1'($urandom), a, d);
            sent++;
         end
         if (idle_on && $urandom_range(0, 99) == 0) drain_words();
      end
   endtask

   // random bursts of response stall
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_got.rom_address  = rsp_rom_address;
         rsp_got.out_of_range = rsp_bank_out_of_range;
         rsp_got.mirror       = rsp_mirroring_mode;
         rsp_got.char_page    = rsp_chr_bank_select;
         rsp_got.prog_page    = rsp_prg_bank_select;
         rsp_checked++;
         if (pending_maps.size() == 0) begin
            mismatches++;
            $display("%0t: expected no word, actual rom=%h oor=%b mir=%0d chr=%0d prg=%0d",
                     $time, rsp_got.rom_address, rsp_got.out_of_range, rsp_got.mirror,
                     rsp_got.char_page, rsp_got.prog_page);
         end else begin
            rsp_want = pending_maps.pop_front();
            if (rsp_got !== rsp_want) begin
               mismatches++;
               $display("%0t: expected rom=%h oor=%b mir=%0d chr=%0d prg=%0d",
                        $time, rsp_want.rom_address, rsp_want.out_of_range,
                        rsp_want.mirror, rsp_want.char_page, rsp_want.prog_page);
               $display("%0t:   actual rom=%h oor=%b mir=%0d chr=%0d prg=%0d",
                        $time, rsp_got.rom_address, rsp_got.out_of_range,
                        rsp_got.mirror, rsp_got.char_page, rsp_got.prog_page);
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_reads();
      test_serial_targets();
      test_bank_counts();
      foreach (phase_counts[i]) begin
         set_bank_count(phase_counts[i]);
         idle_on = (i != 2);
         test_random(270);
      end
      idle_on = 1'b0;
      test_random(200);
      drain_words();
      $display("Sent %0d words (%0d bank count writes); %0d responses compared.",
               words_sent, count_writes, rsp_checked);
      $display("Covered loads to all targets, mid-load clears, both halves, counts 0..31.");
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
